// ===== rtl/ensc_pkg.sv =====
package ensc_pkg;

	localparam int DIV_STAGES = 32;
	localparam int HUM_STAGES = 11;
	localparam int POST_PAD   = 3;

	localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
	localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
	localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
	localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
	localparam logic [2:0] REG_HUMID_CAL   = 3'd4;

	localparam logic signed [31:0] TF_OFS_PRESS = 32'sd128000;
	localparam logic [20:0]        PRESS_BASE   = 21'd1048576;
	localparam logic [63:0]        PRESS_SCALE  = 64'd3125;
	localparam logic signed [31:0] TF_OFS_HUM   = 32'sd76800;
	localparam logic signed [31:0] HUM_MAX      = 32'sd419430400;
	localparam logic signed [31:0] HUM_E_BIAS   = 32'sd2097152;
	localparam logic signed [31:0] HUM_A_RND    = 32'sd16384;
	localparam logic signed [31:0] HUM_C_BIAS   = 32'sd32768;
	localparam logic signed [31:0] HUM_F_RND    = 32'sd8192;

	typedef struct packed {
		logic [47:0] temp_cal;
		logic [63:0] press_a;
		logic [63:0] press_b;
		logic [15:0] press_c;
		logic [63:0] humid;
	} cal_t;

	typedef struct packed {
		logic signed [31:0] tf;
		logic signed [15:0] tc;
		logic [15:0]        raw_humid;
	} side_t;

	typedef struct packed {
		side_t side;
		logic  zero;
		logic  neg;
	} dside_t;

endpackage

// ===== rtl/environment_sensor_compensation_top.sv =====
// Throughput: one item per cycle; the whole pipeline advances together and
// holds in place while a finished result waits for m_axis_tready.
// Depth is set by the pressure divider: 32 stages, two quotient bits each.
// Reset (arst_n low, asynchronous): all stage valid bits and all calibration
// registers clear to zero; no clearing pass follows.
module environment_sensor_compensation_top (
	input  logic         clk,
	input  logic         arst_n,
	// raw_temp[19:0], raw_press[39:20], raw_humid[55:40]
	input  logic [55:0]  s_axis_tdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// fine_temp[31:0], temp_centi[47:32], press_q8[79:48], humid_q10[96:80]
	output logic [103:0] m_axis_tdata,
	// press_valid[0]
	output logic [0:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import ensc_pkg::*;

	cal_t cal_q;

	// pipeline advance: every stage moves when the output slot is free or taken
	logic adv;

	logic               t_vld, pre_vld, div_vld, post_vld, hum_vld;
	logic signed [31:0] t_tf, fine_temp;
	logic signed [15:0] t_tc, temp_centi;
	logic signed [25:0] t_pv1;
	logic [19:0]        t_ap;
	logic [15:0]        t_ah;
	logic [63:0]        pre_mn, div_quot;
	logic [30:0]        pre_md;
	dside_t             pre_side, div_side;
	logic [31:0]        press_q8;
	logic               press_valid;
	logic [16:0]        humid_q10;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	// calibration words; writes beyond the register list drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP_CAL:    cal_q.temp_cal <= cfg_data[47:0];
				REG_PRESS_CAL_A: cal_q.press_a  <= cfg_data;
				REG_PRESS_CAL_B: cal_q.press_b  <= cfg_data;
				REG_PRESS_CAL_C: cal_q.press_c  <= cfg_data[15:0];
				REG_HUMID_CAL:   cal_q.humid    <= cfg_data;
				default: ;
			endcase
		end
	end

	// fine temperature, centi-degrees and the pressure offset term
	ensc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (s_axis_tvalid),
		.raw_temp  (s_axis_tdata[19:0]),
		.raw_press (s_axis_tdata[39:20]),
		.raw_humid (s_axis_tdata[55:40]),
		.cal       (cal_q),
		.out_vld   (t_vld),
		.tf        (t_tf),
		.tc        (t_tc),
		.pv1       (t_pv1),
		.ap        (t_ap),
		.ah        (t_ah)
	);

	// pressure numerator and divisor, reduced to magnitudes and a sign
	ensc_ppre u_ppre (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (t_vld),
		.tf      (t_tf),
		.tc      (t_tc),
		.pv1     (t_pv1),
		.ap      (t_ap),
		.ah      (t_ah),
		.cal     (cal_q),
		.out_vld (pre_vld),
		.mn      (pre_mn),
		.md      (pre_md),
		.dside   (pre_side)
	);

	// unsigned quotient; temperature and raw humidity ride alongside
	ensc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (pre_vld),
		.mn        (pre_mn),
		.md        (pre_md),
		.dside_in  (pre_side),
		.out_vld   (div_vld),
		.quot      (div_quot),
		.dside_out (div_side)
	);

	// pressure correction and saturation, padded to the humidity depth
	ensc_ppost u_ppost (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (div_vld),
		.quot        (div_quot),
		.zero        (div_side.zero),
		.neg         (div_side.neg),
		.cal         (cal_q),
		.out_vld     (post_vld),
		.press_q8    (press_q8),
		.press_valid (press_valid)
	);

	// humidity in a 32-bit datapath; its last stage is the output register
	ensc_humid u_humid (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (div_vld),
		.side       (div_side.side),
		.cal        (cal_q),
		.out_vld    (hum_vld),
		.fine_temp  (fine_temp),
		.temp_centi (temp_centi),
		.humid_q10  (humid_q10)
	);

	assign m_axis_tvalid   = hum_vld;
	assign m_axis_tdata    = {7'd0, humid_q10, press_q8, temp_centi, fine_temp};
	assign m_axis_tuser[0] = press_valid;

`ifndef SYNTHESIS
	a_branch_align: assert property (@(posedge clk) disable iff (!arst_n)
		hum_vld == post_vld)
		else $error("pressure and humidity branches out of step");
	a_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[79:48] == 32'd0)
		else $error("invalid pressure not forced to zero");
	a_humid_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[96:80] <= 17'd102400)
		else $error("humidity above full scale");
	a_tf_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:23] == 9'h000 || m_axis_tdata[31:23] == 9'h1FF))
		else $error("fine temperature beyond its 24-bit range");
`endif
endmodule

// ===== rtl/ensc_temp.sv =====
module ensc_temp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  logic [19:0]        raw_temp,
	input  logic [19:0]        raw_press,
	input  logic [15:0]        raw_humid,
	input  ensc_pkg::cal_t     cal,
	output logic               out_vld,
	output logic signed [31:0] tf,
	output logic signed [15:0] tc,
	output logic signed [25:0] pv1,
	output logic [19:0]        ap,
	output logic [15:0]        ah
);
	import ensc_pkg::*;

	logic [3:0]         vld_s;
	logic signed [33:0] a1_s1, dd_s1, v1t_s2;
	logic signed [37:0] m2_s2;
	logic signed [31:0] tf_s3, tf_s4;
	logic signed [15:0] tc_s4;
	logic signed [25:0] pv1_s4;
	logic [19:0]        ap_s1, ap_s2, ap_s3, ap_s4;
	logic [15:0]        ah_s1, ah_s2, ah_s3, ah_s4;

	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic signed [17:0] dx;
	logic signed [16:0] d;
	logic signed [35:0] t5, sh;
	logic signed [15:0] tc_c;

	assign t1 = cal.temp_cal[15:0];
	assign t2 = cal.temp_cal[31:16];
	assign t3 = cal.temp_cal[47:32];
	assign dx = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d  = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, t1});

	always_comb begin
		t5 = 36'(tf_s3) * 36'sd5 + 36'sd128;
		sh = t5 >>> 8;
		if (sh < -36'sd32768) begin
			tc_c = -16'sd32768;
		end else if (sh > 36'sd32767) begin
			tc_c = 16'sd32767;
		end else begin
			tc_c = 16'(sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s1  <= dx * t2;
			dd_s1  <= d * d;
			ap_s1  <= raw_press;
			ah_s1  <= raw_humid;
			v1t_s2 <= a1_s1 >>> 11;
			m2_s2  <= (dd_s1 >>> 12) * t3;
			ap_s2  <= ap_s1;
			ah_s2  <= ah_s1;
			tf_s3  <= 32'(v1t_s2 + (m2_s2 >>> 14));
			ap_s3  <= ap_s2;
			ah_s3  <= ah_s2;
			tf_s4  <= tf_s3;
			tc_s4  <= tc_c;
			pv1_s4 <= 26'(tf_s3 - TF_OFS_PRESS);
			ap_s4  <= ap_s3;
			ah_s4  <= ah_s3;
		end
	end

	assign out_vld = vld_s[3];
	assign tf      = tf_s4;
	assign tc      = tc_s4;
	assign pv1     = pv1_s4;
	assign ap      = ap_s4;
	assign ah      = ah_s4;
endmodule

// ===== rtl/ensc_ppre.sv =====
module ensc_ppre (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  logic signed [31:0] tf,
	input  logic signed [15:0] tc,
	input  logic signed [25:0] pv1,
	input  logic [19:0]        ap,
	input  logic [15:0]        ah,
	input  ensc_pkg::cal_t     cal,
	output logic               out_vld,
	output logic [63:0]        mn,
	output logic [30:0]        md,
	output ensc_pkg::dside_t   dside
);
	import ensc_pkg::*;

	logic [5:0]         vld_s;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [19:0]        ap_s1, ap_s2, ap_s3;
	logic signed [25:0] pv1_s1;
	logic signed [51:0] sq_s1;
	logic signed [63:0] v2a_s2, sqp3_s2, v2_s3, v1x_s3;
	logic signed [41:0] v1p5_s2, v1p2_s2;
	logic [63:0]        v1y_s4, numa_s4, num_s5;
	logic signed [30:0] den_s5;
	logic [63:0]        mn_s6;
	logic [30:0]        md_s6;
	dside_t             dside_s6;

	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6;
	logic [20:0]        pp;
	logic [63:0]        x47;

	assign p1  = cal.press_a[15:0];
	assign p2  = cal.press_a[31:16];
	assign p3  = cal.press_a[47:32];
	assign p4  = cal.press_a[63:48];
	assign p5  = cal.press_b[15:0];
	assign p6  = cal.press_b[31:16];
	assign pp  = PRESS_BASE - {1'b0, ap_s3};
	assign x47 = (64'd1 << 47) + 64'(v1x_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= '{tf: tf, tc: tc, raw_humid: ah};
			ap_s1   <= ap;
			pv1_s1  <= pv1;
			sq_s1   <= pv1 * pv1;

			side_s2 <= side_s1;
			ap_s2   <= ap_s1;
			v2a_s2  <= 64'(sq_s1) * p6;
			sqp3_s2 <= 64'(sq_s1) * p3;
			v1p5_s2 <= pv1_s1 * p5;
			v1p2_s2 <= pv1_s1 * p2;

			side_s3 <= side_s2;
			ap_s3   <= ap_s2;
			v2_s3   <= 64'(v2a_s2) + (64'(v1p5_s2) <<< 17) + (64'(p4) <<< 35);
			v1x_s3  <= (sqp3_s2 >>> 8) + (64'(v1p2_s2) <<< 12);

			side_s4 <= side_s3;
			v1y_s4  <= x47 * 64'(p1);
			numa_s4 <= (64'(pp) << 31) - 64'(v2_s3);

			side_s5 <= side_s4;
			den_s5  <= $signed(v1y_s4[63:33]);
			num_s5  <= numa_s4 * PRESS_SCALE;

			mn_s6    <= num_s5[63] ? (~num_s5 + 64'd1) : num_s5;
			md_s6    <= den_s5[30] ? (~den_s5 + 31'd1) : den_s5;
			dside_s6 <= '{side: side_s5, zero: (den_s5 == 31'sd0),
				neg: (num_s5[63] ^ den_s5[30])};
		end
	end

	assign out_vld = vld_s[5];
	assign mn      = mn_s6;
	assign md      = md_s6;
	assign dside   = dside_s6;
endmodule

// ===== rtl/ensc_div.sv =====
module ensc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  logic [63:0]      mn,
	input  logic [30:0]      md,
	input  ensc_pkg::dside_t dside_in,
	output logic             out_vld,
	output logic [63:0]      quot,
	output ensc_pkg::dside_t dside_out
);
	import ensc_pkg::*;

	// one restoring step: shift in a numerator bit, subtract when it fits
	function automatic logic [94:0] div_step(input logic [30:0] rem, input logic [63:0] w,
		input logic [30:0] dv);
		logic [31:0] r2;
		logic        qb;
		r2 = {rem, w[63]};
		qb = (r2 >= {1'b0, dv});
		if (qb) begin
			r2 = r2 - {1'b0, dv};
		end
		return {r2[30:0], w[62:0], qb};
	endfunction

	logic [DIV_STAGES-1:0] vld_s;
	logic [30:0]           rem_s  [DIV_STAGES];
	logic [63:0]           w_s    [DIV_STAGES];
	logic [30:0]           md_s   [DIV_STAGES];
	dside_t                side_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DIV_STAGES-2:0], in_vld};
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [30:0] rem_in;
		logic [63:0] w_in;
		logic [30:0] md_in;
		dside_t      side_in;
		logic [94:0] st1, st2;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign w_in    = mn;
			assign md_in   = md;
			assign side_in = dside_in;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign w_in    = w_s[k-1];
			assign md_in   = md_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign st1 = div_step(rem_in, w_in, md_in);
		assign st2 = div_step(st1[94:64], st1[63:0], md_in);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= st2[94:64];
				w_s[k]    <= st2[63:0];
				md_s[k]   <= md_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld   = vld_s[DIV_STAGES-1];
	assign quot      = w_s[DIV_STAGES-1];
	assign dside_out = side_s[DIV_STAGES-1];
endmodule

// ===== rtl/ensc_ppost.sv =====
module ensc_ppost (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_vld,
	input  logic [63:0]    quot,
	input  logic           zero,
	input  logic           neg,
	input  ensc_pkg::cal_t cal,
	output logic           out_vld,
	output logic [31:0]    press_q8,
	output logic           press_valid
);
	import ensc_pkg::*;

	localparam int NST = 8 + POST_PAD;

	logic [NST-1:0]     vld_s;
	logic [6:0]         zero_s;
	logic signed [63:0] q_s1, q_s2, q_s3, q_s4, q_s5;
	logic signed [63:0] t13_s2, pt_s2, v2p_s2, v2p_s3, v2p_s4, v2p_s5;
	logic [63:0]        m0_s3, s_s4, prod_s5;
	logic [31:0]        m1_s3, ptlo_s3, t13hi_s3, m2_s4;
	logic signed [63:0] sum_s6, pf_s7;
	logic [31:0]        pq_s [8:NST];
	logic               pv_s [8:NST];

	logic signed [15:0] p7, p8, p9;
	logic signed [63:0] t13;
	logic [31:0]        pq_c;

	assign p7  = cal.press_b[47:32];
	assign p8  = cal.press_b[63:48];
	assign p9  = cal.press_c;
	assign t13 = q_s1 >>> 13;

	always_comb begin
		if (zero_s[6] || pf_s7[63]) begin
			pq_c = '0;
		end else if (|pf_s7[62:32]) begin
			pq_c = '1;
		end else begin
			pq_c = pf_s7[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s    <= {zero_s[5:0], zero};
			q_s1      <= neg ? $signed(~quot + 64'd1) : $signed(quot);

			q_s2      <= q_s1;
			t13_s2    <= t13;
			pt_s2     <= 64'(p9 * t13);
			v2p_s2    <= 64'(p8 * q_s1);

			q_s3      <= q_s2;
			v2p_s3    <= v2p_s2;
			m0_s3     <= 64'(pt_s2[31:0]) * 64'(t13_s2[31:0]);
			m1_s3     <= pt_s2[63:32] * t13_s2[31:0];
			ptlo_s3   <= pt_s2[31:0];
			t13hi_s3  <= t13_s2[63:32];

			q_s4      <= q_s3;
			v2p_s4    <= v2p_s3;
			m2_s4     <= ptlo_s3 * t13hi_s3;
			s_s4      <= m0_s3 + {m1_s3, 32'd0};

			q_s5      <= q_s4;
			v2p_s5    <= v2p_s4;
			prod_s5   <= s_s4 + {m2_s4, 32'd0};

			sum_s6    <= q_s5 + ($signed(prod_s5) >>> 25) + (v2p_s5 >>> 19);
			pf_s7     <= (sum_s6 >>> 8) + (64'(p7) <<< 4);

			pq_s[8]   <= pq_c;
			pv_s[8]   <= !zero_s[6];
			for (int i = 9; i <= NST; i++) begin
				pq_s[i] <= pq_s[i-1];
				pv_s[i] <= pv_s[i-1];
			end
		end
	end

	assign out_vld     = vld_s[NST-1];
	assign press_q8    = pq_s[NST];
	assign press_valid = pv_s[NST];
endmodule

// ===== rtl/ensc_humid.sv =====
module ensc_humid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  ensc_pkg::side_t    side,
	input  ensc_pkg::cal_t     cal,
	output logic               out_vld,
	output logic signed [31:0] fine_temp,
	output logic signed [15:0] temp_centi,
	output logic [16:0]        humid_q10
);
	import ensc_pkg::*;

	logic [HUM_STAGES-1:0] vld_s;
	logic signed [31:0]    tf_s [HUM_STAGES];
	logic signed [15:0]    tc_s [HUM_STAGES];

	logic signed [31:0] x_s1, ah14_s1, ah14_s2, mh5_s2, xh6_s2, xh3_s2;
	logic signed [31:0] a_s3, b_s3, c_s3, a_s4, a_s5, a_s6, a_s7;
	logic signed [31:0] bc_s4, e_s5, eh2_s6, f_s7, x2_s8, x2_s9, x2_s10;
	logic signed [31:0] gg_s9, gh1_s10;
	logic [16:0]        hq_s11;

	logic signed [31:0] h1, h2, h3, h4, h5, h6, g, x3;

	assign h1 = $signed({24'd0, cal.humid[7:0]});
	assign h2 = 32'($signed(cal.humid[23:8]));
	assign h3 = $signed({24'd0, cal.humid[31:24]});
	assign h4 = 32'($signed(cal.humid[43:32]));
	assign h5 = 32'($signed(cal.humid[55:44]));
	assign h6 = 32'($signed(cal.humid[63:56]));
	assign g  = x2_s8 >>> 15;
	assign x3 = x2_s10 - (gh1_s10 >>> 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[HUM_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tf_s[0] <= side.tf;
			tc_s[0] <= side.tc;
			for (int i = 1; i < HUM_STAGES; i++) begin
				tf_s[i] <= tf_s[i-1];
				tc_s[i] <= tc_s[i-1];
			end

			x_s1    <= side.tf - TF_OFS_HUM;
			ah14_s1 <= $signed({2'd0, side.raw_humid, 14'd0}) - (h4 <<< 20);

			ah14_s2 <= ah14_s1;
			mh5_s2  <= h5 * x_s1;
			xh6_s2  <= x_s1 * h6;
			xh3_s2  <= x_s1 * h3;

			a_s3    <= (ah14_s2 - mh5_s2 + HUM_A_RND) >>> 15;
			b_s3    <= xh6_s2 >>> 10;
			c_s3    <= (xh3_s2 >>> 11) + HUM_C_BIAS;

			a_s4    <= a_s3;
			bc_s4   <= b_s3 * c_s3;
			a_s5    <= a_s4;
			e_s5    <= (bc_s4 >>> 10) + HUM_E_BIAS;
			a_s6    <= a_s5;
			eh2_s6  <= e_s5 * h2;
			a_s7    <= a_s6;
			f_s7    <= (eh2_s6 + HUM_F_RND) >>> 14;
			x2_s8   <= a_s7 * f_s7;
			x2_s9   <= x2_s8;
			gg_s9   <= g * g;
			x2_s10  <= x2_s9;
			gh1_s10 <= (gg_s9 >>> 7) * h1;

			if (x3[31]) begin
				hq_s11 <= '0;
			end else if (x3 > HUM_MAX) begin
				hq_s11 <= HUM_MAX[28:12];
			end else begin
				hq_s11 <= x3[28:12];
			end
		end
	end

	assign out_vld    = vld_s[HUM_STAGES-1];
	assign fine_temp  = tf_s[HUM_STAGES-1];
	assign temp_centi = tc_s[HUM_STAGES-1];
	assign humid_q10  = hq_s11;
endmodule

// ===== verif/ensc_checker.sv =====
module ensc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [55:0]  s_axis_tdata,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [103:0] m_axis_tdata,
	input  logic [0:0]   m_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output int           fails,
	output int           pending
);
	import ensc_pkg::*;

	typedef struct packed {
		logic [31:0] fine_temp;
		logic [15:0] temp_centi;
		logic [31:0] press_q8;
		logic        press_valid;
		logic [16:0] humid_q10;
	} reading_t;

	logic [47:0] cal_temp;
	logic [63:0] cal_pa, cal_pb, cal_h;
	logic [15:0] cal_pc;
	reading_t    readings_due[$];

	function automatic longint quot_trunc(longint n, longint d);
		logic [63:0] mn, md, q;
		mn = (n < 0) ? 64'(-n) : 64'(n);
		md = (d < 0) ? 64'(-d) : 64'(d);
		q  = mn / md;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
		reading_t r;
		longint t1, t2, t3, d, v1, v2, tf, tcw, p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		int x, a, b, c, e, f, g, h1, h2, h3, h4, h5, h6;
		t1 = longint'(cal_temp[15:0]);
		t2 = longint'($signed(cal_temp[31:16]));
		t3 = longint'($signed(cal_temp[47:32]));
		v1 = ((longint'(rt >> 3) - (t1 <<< 1)) * t2) >>> 11;
		d  = longint'(rt >> 4) - t1;
		v2 = (((d * d) >>> 12) * t3) >>> 14;
		tf = v1 + v2;
		r.fine_temp = tf[31:0];
		tcw = (tf * 5 + 128) >>> 8;
		if (tcw < -32768) tcw = -32768;
		if (tcw > 32767) tcw = 32767;
		r.temp_centi = tcw[15:0];

		p1 = longint'(cal_pa[15:0]);
		p2 = longint'($signed(cal_pa[31:16]));
		p3 = longint'($signed(cal_pa[47:32]));
		p4 = longint'($signed(cal_pa[63:48]));
		p5 = longint'($signed(cal_pb[15:0]));
		p6 = longint'($signed(cal_pb[31:16]));
		p7 = longint'($signed(cal_pb[47:32]));
		p8 = longint'($signed(cal_pb[63:48]));
		p9 = longint'($signed(cal_pc));
		v1 = tf - 128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
		r.press_q8 = '0;
		r.press_valid = 1'b0;
		if (v1 != 0) begin
			p  = 1048576 - longint'(rp);
			p  = quot_trunc(((p <<< 31) - v2) * 3125, v1);
			v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			v2 = (p8 * p) >>> 19;
			p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
			if (p < 0) r.press_q8 = '0;
			else if (p > 64'sh0FFFF_FFFF) r.press_q8 = '1;
			else r.press_q8 = p[31:0];
			r.press_valid = 1'b1;
		end

		h1 = int'(cal_h[7:0]);
		h2 = int'($signed(cal_h[23:8]));
		h3 = int'(cal_h[31:24]);
		h4 = int'($signed(cal_h[43:32]));
		h5 = int'($signed(cal_h[55:44]));
		h6 = int'($signed(cal_h[63:56]));
		x = int'(tf[31:0]) - 76800;
		a = (int'(rh) <<< 14) - (h4 <<< 20) - h5 * x;
		a = (a + 16384) >>> 15;
		b = (x * h6) >>> 10;
		c = ((x * h3) >>> 11) + 32768;
		e = ((b * c) >>> 10) + 2097152;
		f = (e * h2 + 8192) >>> 14;
		x = a * f;
		g = x >>> 15;
		x = x - ((((g * g) >>> 7) * h1) >>> 4);
		if (x < 0) x = 0;
		else if (x > 419430400) x = 419430400;
		r.humid_q10 = 17'(x >> 12);
		return r;
	endfunction

	assign pending = readings_due.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t want, got;
		if (!arst_n) begin
			cal_temp <= '0;
			cal_pa <= '0;
			cal_pb <= '0;
			cal_pc <= '0;
			cal_h <= '0;
			fails = 0;
			readings_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEMP_CAL:    cal_temp <= cfg_data[47:0];
					REG_PRESS_CAL_A: cal_pa <= cfg_data;
					REG_PRESS_CAL_B: cal_pb <= cfg_data;
					REG_PRESS_CAL_C: cal_pc <= cfg_data[15:0];
					REG_HUMID_CAL:   cal_h <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				readings_due.push_back(compensate(s_axis_tdata[19:0], s_axis_tdata[39:20],
					s_axis_tdata[55:40]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.fine_temp   = m_axis_tdata[31:0];
				got.temp_centi  = m_axis_tdata[47:32];
				got.press_q8    = m_axis_tdata[79:48];
				got.humid_q10   = m_axis_tdata[96:80];
				got.press_valid = m_axis_tuser[0];
				if (readings_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected result item %h", $time, got);
				end else begin
					want = readings_due.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: mismatch exp tf=%h tc=%h pq=%h pv=%b hq=%h", $time,
							want.fine_temp, want.temp_centi, want.press_q8, want.press_valid,
							want.humid_q10);
						$display("%0t:          got tf=%h tc=%h pq=%h pv=%b hq=%h", $time,
							got.fine_temp, got.temp_centi, got.press_q8, got.press_valid,
							got.humid_q10);
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_environment_sensor_compensation_top.sv =====
module tb_environment_sensor_compensation_top;
	import ensc_pkg::*;

	// Drain wait covers the pipeline depth with margin.
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 600000;

	// Idle modes: none, sender gaps, receiver stalls, both lightly.
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic         clk;
	logic         arst_n;
	logic [55:0]  s_axis_tdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;

	int           fails;
	int           pending;
	int           cycles;
	idle_mode_t   idle_mode;
	logic         rx_hold;

	environment_sensor_compensation_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ensc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** environment_sensor_compensation_top: FAILED **");
			$finish;
		end
	end

	// Drive the result side: stall by mode, or hold off entirely during pressure.
	always @(negedge clk) begin
		if (rx_hold)
			m_axis_tready <= 1'b0;
		else case (idle_mode)
			IDLE_RECEIVER: m_axis_tready <= ($urandom_range(99) >= 86);
			IDLE_BOTH:     m_axis_tready <= ($urandom_range(99) >= 10);
			default:       m_axis_tready <= 1'b1;
		endcase
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_item(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
		int pct;
		pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 10 : 0;
		while ($urandom_range(99) < pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {rh, rp, rt};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Let the pipeline drain before touching calibration.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_cal(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
			logic [15:0] pc, logic [63:0] h);
		wait_idle();
		write_reg(REG_TEMP_CAL, {16'h0, t});
		write_reg(REG_PRESS_CAL_A, pa);
		write_reg(REG_PRESS_CAL_B, pb);
		write_reg(REG_PRESS_CAL_C, {48'h0, pc});
		write_reg(REG_HUMID_CAL, h);
	endtask

	// Typical factory words: T1..T3, P1..P9, H1..H6.
	task automatic load_typical();
		load_cal({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
			16'd6000,
			{8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
	endtask

	task automatic random_items(int n, idle_mode_t mode);
		logic [19:0] rt, rp;
		mode_set: idle_mode = mode;
		repeat (n) begin
			// Mostly plausible readings, the rest full-range noise.
			if ($urandom_range(99) < 70) begin
				rt = 20'($urandom_range(600000, 380000));
				rp = 20'($urandom_range(520000, 200000));
			end else begin
				rt = 20'($urandom);
				rp = 20'($urandom);
			end
			send_item(rt, rp, 16'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_hold       = 1'b0;
		idle_mode     = IDLE_NONE;
		cycles        = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset calibration: pressure divisor is zero, so pressure must be flagged.
		send_item(20'h0, 20'h0, 16'h0);
		send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_item(20'h7EEF0, 20'h51A8C, 16'h6A2B);

		// Typical words: field extremes and corners.
		load_typical();
		send_item(20'h0, 20'h0, 16'h0);
		send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_item(20'hFFFFF, 20'h0, 16'h0);
		send_item(20'h0, 20'hFFFFF, 16'hFFFF);
		send_item(20'h80000, 20'h80000, 16'h8000);
		send_item(20'h7EEF0, 20'h51A8C, 16'h6A2B);
		send_item(20'h7EEF0, 20'h51A8C, 16'h0000);
		send_item(20'h7EEF0, 20'h51A8C, 16'hFFFF);
		send_item(20'd519888, 20'd415148, 16'd30000);
		send_item(20'h55555, 20'hAAAAA, 16'h5555);
		send_item(20'hAAAAA, 20'h55555, 16'hAAAA);

		// Hold the receiver off for a long stretch while items keep coming.
		fork
			begin
				rx_hold = 1'b1;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
			end
		join_none
		random_items(150, IDLE_NONE);

		// Fully random words: exercise wrap and saturation paths.
		load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
			16'($urandom), {$urandom, $urandom});
		random_items(70, IDLE_SENDER);
		load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
			16'($urandom), {$urandom, $urandom});
		random_items(70, IDLE_RECEIVER);

		// All ones, then most negative signed words with maximal unsigned ones.
		load_cal('1, '1, '1, '1, '1);
		random_items(80, IDLE_BOTH);
		load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000,
			{8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
		random_items(80, IDLE_SENDER);
		load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
			{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF,
			{8'h7F, 12'h7FF, 12'h7FF, 8'h00, 16'h7FFF, 8'h00});
		random_items(60, IDLE_RECEIVER);

		// Back to typical words; writes to unmapped indexes must change nothing.
		load_typical();
		write_reg(3'd5, '1);
		write_reg(3'd6, '1);
		write_reg(3'd7, '1);
		random_items(80, IDLE_BOTH);
		random_items(60, IDLE_NONE);

		idle_mode = IDLE_NONE;
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("** environment_sensor_compensation_top: PASSED **");
		else
			$display("** environment_sensor_compensation_top: FAILED **");
		$finish;
	end

endmodule
